// ===== rtl/triangle_mesh_quality_macros.svh =====
// ----------------------------------------------------------------------------
// Triangle mesh quality - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_MESH_QUALITY_MACROS_SVH
`define TRIANGLE_MESH_QUALITY_MACROS_SVH

// same-cycle implication
`define TMQ_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TMQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tmq_pkg.sv =====
// ----------------------------------------------------------------------------
// tmq_pkg
// Types, constants and small tables shared by the mesh quality block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmq_pkg;

  localparam int COORD_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int MUL_W        = 32;
  localparam int PROD_W       = 64;
  localparam int RAD_W        = 64;
  localparam int RES_W        = 32;
  localparam int XW           = 36;
  localparam int ZW           = 26;
  localparam int OUT_W        = 16;
  localparam int STEPS_LONG   = 32;
  localparam int STEPS_CORDIC = 16;

  localparam logic [24:0] DEG90_Q16  = 25'd5898240;
  localparam logic [24:0] DEG180_Q16 = 25'd11796480;

  typedef enum logic [1:0] {
    OP_ROOT,
    OP_DIV,
    OP_CORDIC
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_cmd_t;

  typedef enum logic {
    IT_IDLE,
    IT_RUN
  } iter_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_CHECK,
    ST_LOAD,
    ST_SCALE,
    ST_DOT,
    ST_CROSS,
    ST_ROOT,
    ST_ROOT_W,
    ST_ANGLE,
    ST_ANG_W,
    ST_VEND,
    ST_RATIO,
    ST_DIV_W,
    ST_ASQ_W,
    ST_UPDATE
  } seq_state_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [21:0] atan_q16(input logic [3:0] i);
    logic [21:0] v;
    unique case (i)
      4'd0:  v = 22'd2949120;
      4'd1:  v = 22'd1740967;
      4'd2:  v = 22'd919879;
      4'd3:  v = 22'd466945;
      4'd4:  v = 22'd234379;
      4'd5:  v = 22'd117304;
      4'd6:  v = 22'd58666;
      4'd7:  v = 22'd29335;
      4'd8:  v = 22'd14668;
      4'd9:  v = 22'd7334;
      4'd10: v = 22'd3667;
      4'd11: v = 22'd1833;
      4'd12: v = 22'd917;
      4'd13: v = 22'd458;
      4'd14: v = 22'd229;
      4'd15: v = 22'd115;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] pick3(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic signed [31:0] c,
                                               input logic [1:0] s);
    logic signed [31:0] v;
    unique case (s)
      2'd0:    v = a;
      2'd1:    v = b;
      default: v = c;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tmq_mul.sv =====
// ----------------------------------------------------------------------------
// tmq_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_mul import tmq_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// ===== rtl/tmq_iter.sv =====
// ----------------------------------------------------------------------------
// tmq_iter
// Shared iterative unit: square root (2 bits/step), restoring division
// (1 bit/step) on one subtractor, and 16-step CORDIC vectoring.
// ----------------------------------------------------------------------------
`default_nettype none

module tmq_iter import tmq_pkg::*; #(
  parameter int LEN_W = 2 * COORD_BITS_DEF + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  iter_cmd_t              cmd,
  input  logic [RAD_W-1:0]       rad,
  input  logic [LEN_W-1:0]       div_hi,
  input  logic [LEN_W-1:0]       divisor,
  input  logic [31:0]            div_lo,
  input  logic signed [XW-1:0]   x0,
  input  logic signed [XW-1:0]   y0,
  input  logic signed [ZW-1:0]   z0,
  output logic                   done,
  output logic [RES_W-1:0]       res,
  output logic signed [ZW-1:0]   zout
);

  localparam int RW = (LEN_W + 1 > 36) ? LEN_W + 1 : 36;

  iter_state_t state, state_next;
  iter_op_t    op;
  logic [4:0]  cnt;
  logic        last_step;
  logic        finish;

  logic [RAD_W-1:0]      src;
  logic [RW-1:0]         rem;
  logic signed [XW-1:0]  x, y;
  logic signed [ZW-1:0]  z;

  logic [RW-1:0]         rsh, subv;
  logic [RW:0]           diff;
  logic                  ge;
  logic signed [XW-1:0]  dx, dy;
  logic signed [ZW-1:0]  ang_step;

  assign last_step = (op == OP_CORDIC) ? (cnt == 5'(STEPS_CORDIC - 1))
                                       : (cnt == 5'(STEPS_LONG - 1));

  always_comb begin
    if (op == OP_DIV) begin
      rsh  = {rem[RW-2:0], src[RAD_W-1]};
      subv = RW'(divisor);
    end else begin
      rsh  = {rem[RW-3:0], src[RAD_W-1 -: 2]};
      subv = RW'({res, 2'b01});
    end
    diff     = {1'b0, rsh} - {1'b0, subv};
    ge       = !diff[RW];
    dx       = y >>> cnt[3:0];
    dy       = x >>> cnt[3:0];
    ang_step = ZW'(atan_q16(cnt[3:0]));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      IT_IDLE: if (cmd.start) state_next = IT_RUN;
      IT_RUN:  if (last_step) state_next = IT_IDLE;
      default: state_next = IT_IDLE;
    endcase
  end

  always_comb begin
    finish = (state == IT_RUN) && last_step;
    zout   = z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IT_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (state == IT_IDLE && cmd.start) begin
      op  <= cmd.op;
      cnt <= '0;
      res <= '0;
      x   <= x0;
      y   <= y0;
      z   <= z0;
      if (cmd.op == OP_DIV) begin
        src <= {div_lo, 32'b0};
        rem <= RW'(div_hi);
      end else begin
        src <= rad;
        rem <= '0;
      end
    end else if (state == IT_RUN) begin
      cnt <= cnt + 5'd1;
      if (op == OP_CORDIC) begin
        if (y >= 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + ang_step;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - ang_step;
        end
      end else begin
        res <= {res[RES_W-2:0], ge};
        rem <= ge ? diff[RW-1:0] : rsh;
        src <= (op == OP_DIV) ? (src << 1) : (src << 2);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/triangle_mesh_quality.sv =====
// ----------------------------------------------------------------------------
// triangle_mesh_quality
// Running min/max interior angle and max edge aspect ratio over a mesh,
// reported on the last element.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | ax..cz, is_triangle, last_element
//  out     | out_valid / out_stall| min_angle_deg, max_angle_deg, peak_aspect,
//          |                      | mesh_ok
//
//  A non-triangle element goes straight to update; a zero-length edge skips
//  the angles and ratio. A full triangle takes S scale steps over the three
//  corners (at most 3*max(0, COORD_BITS-15)); a corner with no CORDIC and a
//  saturated ratio (no divide or root) skip those runs. The shared iterative
//  unit runs 32-step root and divide, 16-step CORDIC; the multiplier is shared.
//  Synchronous active-high reset; no clearing pass. A result waits in the
//  output register; a last element stalls only while the previous one is held.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_mesh_quality_macros.svh"

module triangle_mesh_quality import tmq_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] bz,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] cz,
  input  logic                         is_triangle,
  input  logic                         last_element,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [OUT_W-1:0]             min_angle_deg,
  output logic [OUT_W-1:0]             max_angle_deg,
  output logic [OUT_W-1:0]             peak_aspect,
  output logic                         mesh_ok
);

  localparam int E_W    = COORD_BITS + 1;
  localparam int MAG_W  = (COORD_BITS > 15) ? COORD_BITS : 15;
  localparam int LEN_W  = 2 * COORD_BITS + 2;
  localparam int ANG_W  = FRAC_BITS + 8;
  localparam int NUM_W  = LEN_W + 2 * FRAC_BITS + 32;
  localparam int SAT_SH = 32 - 2 * FRAC_BITS;
  localparam int RND    = 1 << (15 - FRAC_BITS);
  localparam logic [ANG_W-1:0] ANG_FULL = ANG_W'(180 << FRAC_BITS);
  localparam logic [OUT_W-1:0] ASP_SAT  = '1;

  seq_state_t state, state_next;

  logic signed [E_W-1:0]  dv [3][3];
  logic signed [E_W-1:0]  ed [3][3];
  logic                   tri_r, last_r;
  logic [1:0]             cnt, sub, vi;
  logic                   ph;
  logic [LEN_W-1:0]       len [3];
  logic [MAG_W-1:0]       umag [3];
  logic [MAG_W-1:0]       vmag [3];
  logic [2:0]             usgn, vsgn;
  logic signed [33:0]     dot;
  logic signed [31:0]     cacc;
  logic [63:0]            cs;
  logic [31:0]            cn;
  logic signed [ZW-1:0]   zsel;
  logic [ANG_W-1:0]       tmin, tmax;
  logic [OUT_W-1:0]       asp;
  logic [ANG_W-1:0]       run_min, run_max;
  logic [OUT_W-1:0]       run_asp;

  logic signed [31:0]     ek [3];
  logic signed [31:0]     lu [3];
  logic signed [31:0]     lv [3];
  logic signed [31:0]     au [3];
  logic signed [31:0]     av [3];
  logic [MAG_W-1:0]       umag_ld [3];
  logic [MAG_W-1:0]       vmag_ld [3];
  logic signed [15:0]     su [3];
  logic signed [15:0]     sv [3];
  logic                   u_big, v_big, len_zero, sat, upd_fire, hold;
  logic [LEN_W-1:0]       lmax, lmin;
  logic [NUM_W-1:0]       numv;
  logic [24:0]            zc, zr;
  logic [ANG_W-1:0]       ang;
  logic [ANG_W-1:0]       nmin, nmax;
  logic [OUT_W-1:0]       nasp;

  logic signed [MUL_W-1:0]  opa, opb;
  logic signed [PROD_W-1:0] prod;
  iter_cmd_t                it_cmd;
  logic [RAD_W-1:0]         it_rad;
  logic signed [XW-1:0]     it_x0, it_y0;
  logic signed [ZW-1:0]     it_z0;
  logic                     it_done;
  logic [RES_W-1:0]         it_res;
  logic signed [ZW-1:0]     it_z;

  tmq_mul u_mul (
    .clk (clk),
    .a   (opa),
    .b   (opb),
    .p   (prod)
  );

  tmq_iter #(
    .LEN_W (LEN_W)
  ) u_iter (
    .clk     (clk),
    .rst     (rst),
    .cmd     (it_cmd),
    .rad     (it_rad),
    .div_hi  (LEN_W'(numv >> 32)),
    .divisor (lmin),
    .div_lo  (numv[31:0]),
    .x0      (it_x0),
    .y0      (it_y0),
    .z0      (it_z0),
    .done    (it_done),
    .res     (it_res),
    .zout    (it_z)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ed[0][k] = '0;
    end
    ed[0][0] = E_W'(bx) - E_W'(ax);
    ed[0][1] = E_W'(by) - E_W'(ay);
    ed[0][2] = E_W'(bz) - E_W'(az);
    ed[1][0] = E_W'(cx) - E_W'(bx);
    ed[1][1] = E_W'(cy) - E_W'(by);
    ed[1][2] = E_W'(cz) - E_W'(bz);
    ed[2][0] = E_W'(ax) - E_W'(cx);
    ed[2][1] = E_W'(ay) - E_W'(cy);
    ed[2][2] = E_W'(az) - E_W'(cz);
  end

  always_comb begin
    u_big = 1'b0;
    v_big = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ek[k] = pick3(32'(dv[0][k]), 32'(dv[1][k]), 32'(dv[2][k]), sub);
      lu[k] = pick3(32'(dv[0][k]), 32'(dv[1][k]), 32'(dv[2][k]), vi);
      lv[k] = pick3(32'(dv[2][k]), 32'(dv[1][k] - dv[1][k] + dv[0][k]),
                    32'(dv[1][k]), vi);
      au[k] = (lu[k] < 0) ? -lu[k] : lu[k];
      av[k] = (lv[k] < 0) ? -lv[k] : lv[k];
      umag_ld[k] = MAG_W'(au[k][COORD_BITS-1:0]);
      vmag_ld[k] = MAG_W'(av[k][COORD_BITS-1:0]);
      su[k] = usgn[k] ? -$signed({1'b0, umag[k][14:0]}) : $signed({1'b0, umag[k][14:0]});
      sv[k] = vsgn[k] ? -$signed({1'b0, vmag[k][14:0]}) : $signed({1'b0, vmag[k][14:0]});
      if ((umag[k] >> 15) != '0) u_big = 1'b1;
      if ((vmag[k] >> 15) != '0) v_big = 1'b1;
    end
  end

  always_comb begin
    len_zero = (len[0] == '0) || (len[1] == '0) || (len[2] == '0);
    lmax = len[0];
    lmin = len[0];
    if (len[1] > lmax) lmax = len[1];
    if (len[2] > lmax) lmax = len[2];
    if (len[1] < lmin) lmin = len[1];
    if (len[2] < lmin) lmin = len[2];
    sat  = (lmax >> SAT_SH) >= lmin;
    numv = NUM_W'(lmax) << (2 * FRAC_BITS);
  end

  always_comb begin
    if (zsel[ZW-1]) begin
      zc = '0;
    end else if (zsel > ZW'(DEG180_Q16)) begin
      zc = DEG180_Q16;
    end else begin
      zc = zsel[24:0];
    end
    zr  = zc + 25'(RND);
    ang = ANG_W'(zr >> (16 - FRAC_BITS));
  end

  always_comb begin
    hold     = last_r && out_valid && out_stall;
    upd_fire = (state == ST_UPDATE) && !hold;
    nmin = (tri_r && tmin < run_min) ? tmin : run_min;
    nmax = (tri_r && tmax > run_max) ? tmax : run_max;
    nasp = (tri_r && asp > run_asp) ? asp : run_asp;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = is_triangle ? ST_LEN : ST_UPDATE;
      ST_LEN:    if (ph && cnt == 2'd2 && sub == 2'd2) state_next = ST_CHECK;
      ST_CHECK:  state_next = len_zero ? ST_UPDATE : ST_LOAD;
      ST_LOAD:   state_next = ST_SCALE;
      ST_SCALE:  if (!u_big && !v_big) state_next = ST_DOT;
      ST_DOT:    if (ph && cnt == 2'd2) state_next = ST_CROSS;
      ST_CROSS:  if (ph && cnt == 2'd2 && sub == 2'd2) state_next = ST_ROOT;
      ST_ROOT:   state_next = ST_ROOT_W;
      ST_ROOT_W: if (it_done) state_next = ST_ANGLE;
      ST_ANGLE:  state_next = (cn == '0 || dot == '0) ? ST_VEND : ST_ANG_W;
      ST_ANG_W:  if (it_done) state_next = ST_VEND;
      ST_VEND:   state_next = (vi == 2'd2) ? ST_RATIO : ST_LOAD;
      ST_RATIO:  state_next = sat ? ST_UPDATE : ST_DIV_W;
      ST_DIV_W:  if (it_done) state_next = ST_ASQ_W;
      ST_ASQ_W:  if (it_done) state_next = ST_UPDATE;
      ST_UPDATE: if (!hold) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state != ST_IDLE);
    it_cmd.start = 1'b0;
    it_cmd.op    = OP_ROOT;
    it_rad       = cs;
    opa          = '0;
    opb          = '0;
    if (dot > 0) begin
      it_x0 = XW'(dot);
      it_y0 = $signed(XW'(cn));
      it_z0 = '0;
    end else begin
      it_x0 = $signed(XW'(cn));
      it_y0 = -XW'(dot);
      it_z0 = ZW'(DEG90_Q16);
    end
    unique case (state)
      ST_LEN: begin
        opa = pick3(ek[0], ek[1], ek[2], cnt);
        opb = opa;
      end
      ST_DOT: begin
        opa = pick3(32'(su[0]), 32'(su[1]), 32'(su[2]), cnt);
        opb = pick3(32'(sv[0]), 32'(sv[1]), 32'(sv[2]), cnt);
      end
      ST_CROSS: begin
        if (sub == 2'd0) begin
          opa = pick3(32'(su[1]), 32'(su[2]), 32'(su[0]), cnt);
          opb = pick3(32'(sv[2]), 32'(sv[0]), 32'(sv[1]), cnt);
        end else if (sub == 2'd1) begin
          opa = pick3(32'(su[2]), 32'(su[0]), 32'(su[1]), cnt);
          opb = pick3(32'(sv[1]), 32'(sv[2]), 32'(sv[0]), cnt);
        end else begin
          opa = cacc;
          opb = cacc;
        end
      end
      ST_ROOT: begin
        it_cmd.start = 1'b1;
        it_cmd.op    = OP_ROOT;
      end
      ST_ANGLE: begin
        it_cmd.start = (cn != '0) && (dot != '0);
        it_cmd.op    = OP_CORDIC;
      end
      ST_RATIO: begin
        it_cmd.start = !sat;
        it_cmd.op    = OP_DIV;
      end
      ST_DIV_W: begin
        it_cmd.start = it_done;
        it_cmd.op    = OP_ROOT;
        it_rad       = RAD_W'(it_res);
      end
      default: begin
        it_cmd.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      run_min   <= ANG_FULL;
      run_max   <= '0;
      run_asp   <= '0;
    end else begin
      state <= state_next;
      if (upd_fire && last_r) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (upd_fire) begin
        if (last_r) begin
          run_min   <= ANG_FULL;
          run_max   <= '0;
          run_asp   <= '0;
        end else begin
          run_min <= nmin;
          run_max <= nmax;
          run_asp <= nasp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire && last_r) begin
      min_angle_deg <= OUT_W'(nmin);
      max_angle_deg <= OUT_W'(nmax);
      peak_aspect   <= nasp;
      mesh_ok       <= (nmin != '0) && (nmax < ANG_FULL);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          dv     <= ed;
          tri_r  <= is_triangle;
          last_r <= last_element;
          cnt    <= '0;
          sub    <= '0;
          vi     <= '0;
          ph     <= 1'b0;
          for (int e = 0; e < 3; e++) len[e] <= '0;
        end
      end
      ST_LEN: begin
        ph <= ~ph;
        if (ph) begin
          len[sub] <= len[sub] + LEN_W'(prod);
          if (cnt == 2'd2) begin
            cnt <= '0;
            sub <= sub + 2'd1;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
      end
      ST_CHECK: begin
        if (len_zero) begin
          tmin <= '0;
          tmax <= '0;
          asp  <= ASP_SAT;
        end
      end
      ST_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          umag[k] <= umag_ld[k];
          vmag[k] <= vmag_ld[k];
          usgn[k] <= lu[k] < 0;
          vsgn[k] <= lv[k] > 0;
        end
        dot <= '0;
        cs  <= '0;
        cnt <= '0;
        sub <= '0;
        ph  <= 1'b0;
      end
      ST_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          if (u_big) umag[k] <= umag[k] >> 1;
          if (v_big) vmag[k] <= vmag[k] >> 1;
        end
      end
      ST_DOT: begin
        ph <= ~ph;
        if (ph) begin
          dot <= dot + 34'(prod);
          cnt <= (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
        end
      end
      ST_CROSS: begin
        ph <= ~ph;
        if (ph) begin
          if (sub == 2'd0) begin
            cacc <= 32'(prod);
          end else if (sub == 2'd1) begin
            cacc <= cacc - 32'(prod);
          end else begin
            cs <= cs + $unsigned(prod);
          end
          if (sub == 2'd2) begin
            sub <= '0;
            cnt <= cnt + 2'd1;
          end else begin
            sub <= sub + 2'd1;
          end
        end
      end
      ST_ROOT_W: begin
        if (it_done) cn <= it_res;
      end
      ST_ANGLE: begin
        if (cn == '0) begin
          zsel <= (dot >= 0) ? '0 : ZW'(DEG180_Q16);
        end else if (dot == '0) begin
          zsel <= ZW'(DEG90_Q16);
        end
      end
      ST_ANG_W: begin
        if (it_done) zsel <= it_z;
      end
      ST_VEND: begin
        if (vi == 2'd0) begin
          tmin <= ang;
          tmax <= ang;
        end else begin
          if (ang < tmin) tmin <= ang;
          if (ang > tmax) tmax <= ang;
        end
        vi <= vi + 2'd1;
      end
      ST_RATIO: begin
        if (sat) asp <= ASP_SAT;
      end
      ST_ASQ_W: begin
        if (it_done) asp <= (it_res[RES_W-1:OUT_W] != '0) ? ASP_SAT : it_res[OUT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  `TMQ_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall,
                   "transaction accepted but block not busy next cycle")
  `TMQ_ASSERT_IMP(a_out_from_update, $rose(out_valid), $past(state) == ST_UPDATE,
                  "result raised outside the update step")
  `TMQ_ASSERT_IMP(a_done_expected, it_done,
                  state == ST_ROOT_W || state == ST_ANG_W ||
                  state == ST_DIV_W || state == ST_ASQ_W,
                  "iterative unit finished while the sequencer was not waiting")
  `TMQ_ASSERT_IMP(a_min_range, 1'b1, run_min <= ANG_FULL,
                  "running minimum angle above 180 degrees")

endmodule

`default_nettype wire
